/* rtl/core/plsc_pkg.sv */
// Shared types, constants and field widths for the piecewise-linear
// sensor calibration unit. No dependencies.
package plsc_pkg;

    // Default table depth.
    localparam int POINTS_DEF = 19;

    // Field widths of the request and result channels.
    localparam int IDX_W    = 5;
    localparam int CODE_W   = 15;
    localparam int PTEMP_W  = 16;
    localparam int SAMPLE_W = 16;
    localparam int TEMP_W   = 12;
    localparam int STATUS_W = 2;

    // Quotient bits of the rounding divider; the interpolated magnitude never exceeds 2048.
    localparam int QUO_W = 12;

    // Request operation codes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INTERP = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FIRST  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LAST   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd3;

    localparam logic signed [TEMP_W-1:0] NO_SEG_TEMP = -12'sd999;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MUL1,
        S_MUL2,
        S_SUM,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        SEL_INTERP,
        SEL_FIRST,
        SEL_LAST,
        SEL_NONE
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     capture;
        logic     scan_start;
        logic     rd_en;
        logic     mul_first;
        logic     mul_second;
        logic     sum;
        logic     div_step;
        logic     out_load;
        t_res_sel sel;
    } t_cmd;

    typedef struct packed {
        logic ge_first;
        logic le_last;
        logic hit;
        logic scan_done;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

/* rtl/core/plsc_ctrl.sv */
// Sequencing state machine of the calibration unit.
// Depends on plsc_pkg for the state, command and status types.
module plsc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_op,
    input  plsc_pkg::t_stat i_stat,
    output logic            o_stall,
    output plsc_pkg::t_cmd  o_cmd
);
    import plsc_pkg::*;

    t_state   r_state;
    t_state   n_state;
    t_res_sel r_sel;
    t_res_sel n_sel;
    logic     accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_NONE;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.sel = r_sel;
        o_stall = (r_state != S_IDLE);
        accept  = i_valid && !o_stall;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.scan_start = 1'b1;
                if (i_stat.ge_first) begin
                    n_sel   = SEL_FIRST;
                    n_state = S_OUT;
                end else if (i_stat.le_last) begin
                    n_sel   = SEL_LAST;
                    n_state = S_OUT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    n_state = S_MUL1;
                end else if (i_stat.scan_done) begin
                    n_sel   = SEL_NONE;
                    n_state = S_OUT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                end
            end
            S_MUL1: begin
                o_cmd.mul_first = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_second = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_sel   = SEL_INTERP;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/plsc_dpath.sv */
// Datapath of the calibration unit: table memory, segment search registers,
// shared multiplier, restoring divider and result register. Depends on plsc_pkg.
module plsc_dpath #(
    parameter int POINTS = plsc_pkg::POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  plsc_pkg::t_cmd                       i_cmd,
    output plsc_pkg::t_stat                      o_stat,
    input  logic [plsc_pkg::IDX_W-1:0]           i_point_index,
    input  logic [plsc_pkg::CODE_W-1:0]          i_point_code,
    input  logic signed [plsc_pkg::PTEMP_W-1:0]  i_point_temp,
    input  logic signed [plsc_pkg::SAMPLE_W-1:0] i_sample_code,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic signed [plsc_pkg::TEMP_W-1:0]   o_temperature,
    output logic [plsc_pkg::STATUS_W-1:0]        o_status
);
    import plsc_pkg::*;

    localparam int AW     = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int PW     = $clog2(POINTS + 1);
    localparam int WORD_W = CODE_W + PTEMP_W;
    localparam int RW     = 34;
    localparam int CW     = $clog2(QUO_W);
    localparam int XW     = SAMPLE_W + 1;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

    function automatic logic signed [TEMP_W-1:0] trunc16(input logic signed [PTEMP_W-1:0] t);
        logic signed [PTEMP_W:0] b;
        b = {t[PTEMP_W-1], t} + (t[PTEMP_W-1] ? (PTEMP_W+1)'(15) : '0);
        return b[TEMP_W+3:4];
    endfunction

    // Table storage; valid bits make never-written entries read as zero.
    logic [WORD_W-1:0]         r_mem [POINTS];
    logic [POINTS-1:0]         r_vld;
    logic [WORD_W-1:0]         r_rd_word;
    logic                      r_rd_vld;
    logic [PW-1:0]             r_ptr;
    logic                      r_pair_ok;
    logic [CODE_W-1:0]         r_prev_v;
    logic signed [PTEMP_W-1:0] r_prev_t;
    logic signed [SAMPLE_W-1:0] r_x;
    logic [CODE_W-1:0]         r_v0;
    logic [CODE_W-1:0]         r_vl;
    logic signed [PTEMP_W-1:0] r_t0;
    logic signed [PTEMP_W-1:0] r_tl;
    logic signed [32:0]        r_p1;
    logic signed [32:0]        r_p2;
    logic [CODE_W-1:0]         r_den;
    logic [RW-1:0]             r_rem;
    logic [RW-1:0]             r_dsr;
    logic [QUO_W-1:0]          r_q;
    logic                      r_neg;
    logic [CW-1:0]             r_div_cnt;
    logic                      r_out_vld;
    logic signed [TEMP_W-1:0]  r_out_temp;
    logic [STATUS_W-1:0]       r_out_status;

    logic                      wr_ok;
    logic [AW-1:0]             wr_addr;
    logic                      rd_go;
    logic [CODE_W-1:0]         cur_v;
    logic signed [PTEMP_W-1:0] cur_t;
    logic signed [XW-1:0]      xs;
    logic [CODE_W-1:0]         den;
    logic [SAMPLE_W-1:0]       dvx;
    logic signed [PTEMP_W:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;
    logic signed [32:0]        prod;
    logic signed [RW-1:0]      num;
    logic [RW-1:0]             mag;
    logic [TEMP_W:0]           neg_q;
    logic signed [TEMP_W-1:0]  interp_t;

    assign wr_ok   = i_cmd.load && (32'(i_point_index) < 32'(POINTS));
    assign wr_addr = AW'(i_point_index);
    assign rd_go   = i_cmd.rd_en && (r_ptr != PW'(POINTS));

    assign cur_v = r_rd_vld ? r_rd_word[WORD_W-1:PTEMP_W] : '0;
    assign cur_t = r_rd_vld ? signed'(r_rd_word[PTEMP_W-1:0]) : '0;
    assign xs    = {r_x[SAMPLE_W-1], r_x};

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_addr] <= {i_point_code, i_point_temp};
        end
        if (rd_go) begin
            r_rd_word <= r_mem[r_ptr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_ptr     <= '0;
            r_pair_ok <= 1'b0;
            r_v0      <= '0;
            r_t0      <= '0;
            r_vl      <= '0;
            r_tl      <= '0;
            r_div_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (wr_ok) begin
                r_vld[wr_addr] <= 1'b1;
                if (i_point_index == '0) begin
                    r_v0 <= i_point_code;
                    r_t0 <= i_point_temp;
                end
                if (32'(i_point_index) == 32'(POINTS - 1)) begin
                    r_vl <= i_point_code;
                    r_tl <= i_point_temp;
                end
            end
            if (i_cmd.scan_start) begin
                r_ptr     <= '0;
                r_pair_ok <= 1'b0;
            end else if (rd_go) begin
                r_ptr     <= r_ptr + 1'b1;
                r_pair_ok <= (r_ptr != '0);
                r_rd_vld  <= r_vld[r_ptr[AW-1:0]];
            end
            if (i_cmd.sum) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Segment arithmetic on the pair held in r_prev and the read register.
    assign den   = r_prev_v - cur_v;
    assign dvx   = {1'b0, r_prev_v} - r_x;
    assign mul_a = i_cmd.mul_second ? ({cur_t[PTEMP_W-1], cur_t} - {r_prev_t[PTEMP_W-1], r_prev_t})
                                    : {r_prev_t[PTEMP_W-1], r_prev_t};
    assign mul_b = i_cmd.mul_second ? signed'(dvx) : signed'({1'b0, den});
    assign prod  = mul_a * mul_b;
    assign num   = {r_p1[32], r_p1} + {r_p2[32], r_p2};
    assign mag   = num[RW-1] ? RW'(-num) : RW'(num);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x <= i_sample_code;
        end
        if (rd_go) begin
            r_prev_v <= cur_v;
            r_prev_t <= cur_t;
        end
        if (i_cmd.mul_first) begin
            r_p1  <= prod;
            r_den <= den;
        end
        if (i_cmd.mul_second) begin
            r_p2 <= prod;
        end
        if (i_cmd.sum) begin
            // Round half away from zero: (2|num| + 16den) / (32den).
            r_neg <= num[RW-1];
            r_rem <= {mag[RW-2:0], 1'b0} + (RW'(r_den) << 4);
            r_dsr <= RW'(r_den) << (QUO_W + 4);
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dsr) begin
                r_rem <= r_rem - r_dsr;
                r_q   <= {r_q[QUO_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[QUO_W-2:0], 1'b0};
            end
            r_dsr <= r_dsr >> 1;
        end
    end

    assign neg_q = -{1'b0, r_q};

    always_comb begin
        if (!r_neg) begin
            interp_t = r_q[QUO_W-1] ? TEMP_MAX : signed'(r_q);
        end else begin
            interp_t = (r_q[QUO_W-1] && (|r_q[QUO_W-2:0])) ? TEMP_MIN
                                                           : signed'(neg_q[TEMP_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.sel)
                SEL_FIRST: begin
                    r_out_temp   <= trunc16(r_t0);
                    r_out_status <= ST_FIRST;
                end
                SEL_LAST: begin
                    r_out_temp   <= trunc16(r_tl);
                    r_out_status <= ST_LAST;
                end
                SEL_INTERP: begin
                    r_out_temp   <= interp_t;
                    r_out_status <= ST_INTERP;
                end
                default: begin
                    r_out_temp   <= NO_SEG_TEMP;
                    r_out_status <= ST_NONE;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.ge_first  = xs >= signed'({2'b00, r_v0});
        o_stat.le_last   = xs <= signed'({2'b00, r_vl});
        o_stat.hit       = r_pair_ok && (xs <= signed'({2'b00, r_prev_v}))
                                     && (xs > signed'({2'b00, cur_v}));
        o_stat.scan_done = r_pair_ok && (r_ptr == PW'(POINTS));
        o_stat.div_last  = (r_div_cnt == CW'(QUO_W - 1));
        o_stat.out_free  = !r_out_vld || !i_stall;
    end

    assign o_valid       = r_out_vld;
    assign o_temperature = r_out_temp;
    assign o_status      = r_out_status;

endmodule

/* rtl/core/piecewise_linear_sensor_calibration_unit.sv */
// Top level of the piecewise-linear sensor calibration unit.
// Depends on plsc_pkg, plsc_ctrl and plsc_dpath.
//
//   Channel   Direction  Handshake            Payload
//   request   in         i_valid / o_stall    i_op, i_point_index, i_point_code,
//                                             i_point_temp, i_sample_code
//   result    out        o_valid / i_stall    o_temperature, o_status
//
// A load request writes one table entry when i_point_index is below POINTS; it gives no result.
// A convert request that clamps at either end of the table goes straight from the range
// check to the output register. One that interpolates runs a serial segment search that
// reads one table entry per cycle from the table memory, then two products on the shared
// multiplier, their sum and twelve divider steps follow.
// Synchronous active-low reset clears the table to zeros through per-entry valid bits,
// with no clearing pass. The block takes the next request while a finished result
// still waits in the output register under i_stall.
module piecewise_linear_sensor_calibration_unit #(
    parameter int POINTS = plsc_pkg::POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_op,
    input  logic [plsc_pkg::IDX_W-1:0]           i_point_index,
    input  logic [plsc_pkg::CODE_W-1:0]          i_point_code,
    input  logic signed [plsc_pkg::PTEMP_W-1:0]  i_point_temp,
    input  logic signed [plsc_pkg::SAMPLE_W-1:0] i_sample_code,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [plsc_pkg::TEMP_W-1:0]   o_temperature,
    output logic [plsc_pkg::STATUS_W-1:0]        o_status
);
    import plsc_pkg::*;

    // The controller sequences each request; the datapath holds every table
    // entry, the search registers, the arithmetic and the result register.
    t_cmd  cmd;
    t_stat stat;

    plsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    plsc_dpath #(
        .POINTS (POINTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_point_index (i_point_index),
        .i_point_code  (i_point_code),
        .i_point_temp  (i_point_temp),
        .i_sample_code (i_sample_code),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_temperature (o_temperature),
        .o_status      (o_status)
    );

endmodule

/* rtl/core/plsc_chk.sv */
// Port-level checker for the calibration unit, bound to the top level.
// Depends on plsc_pkg for the operation and status codes.
module plsc_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic                                 i_op,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [plsc_pkg::TEMP_W-1:0]   o_temperature,
    input logic [plsc_pkg::STATUS_W-1:0]        o_status
);
    import plsc_pkg::*;

    // A result held back by the receiver stays in place.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_temperature) && $stable(o_status))
        else $error("result changed while stalled");

    // A convert request keeps the block busy in the following cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_op == OP_CONVERT) |=> o_stall)
        else $error("convert request did not occupy the block");

    // A new result appears only after the block was busy with a request.
    a_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without a busy period");

    // A missing segment always reports the fixed error temperature.
    a_noseg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_NONE) |-> o_temperature == NO_SEG_TEMP)
        else $error("no-segment result with wrong temperature");

endmodule

bind piecewise_linear_sensor_calibration_unit plsc_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .i_op          (i_op),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_temperature (o_temperature),
    .o_status      (o_status)
);
